// ===== rtl/pre_pkg.sv =====
// pre_pkg: shared types, constants and lookup functions for the polyline ribbon extruder
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none
package pre_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W    = 40;
    localparam int Z_W        = 32;
    localparam int REL_W      = 32;
    localparam int CLS_W      = 3;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int HW_W       = 11;
    localparam int LIFT_W     = 7;
    localparam int ST_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_Z  = 2'd1;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd2;
    localparam logic [ST_W-1:0] ST_OVF   = 2'd3;

    typedef struct packed {
        logic                    ok;
        logic signed [Z_W-1:0]   z;
        logic signed [REL_W-1:0] y;
        logic signed [REL_W-1:0] x;
    } pt_word_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        pt_word_t         data;
    } mem_wr_t;

    typedef struct packed {
        logic             status_only;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] fv;
        logic [CLS_W-1:0] cls;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE, B_FV, B_P0, B_P1, B_NRD, B_NCAP, B_TAN, B_NORM,
        B_SQ, B_SUM, B_SQRT, B_MUL, B_DIV, B_FIN, B_OUT
    } back_state_t;

    function automatic logic [HW_W-1:0] half_width(input logic [CLS_W-1:0] cls);
        logic [HW_W-1:0] r;
        unique case (cls)
            3'd0:    r = 11'd1408;
            3'd1:    r = 11'd1152;
            3'd2:    r = 11'd896;
            3'd3:    r = 11'd704;
            3'd4:    r = 11'd320;
            default: r = 11'd640;
        endcase
        return r;
    endfunction

    function automatic logic [LIFT_W-1:0] lift(input logic [CLS_W-1:0] cls);
        logic [LIFT_W-1:0] r;
        unique case (cls)
            3'd0:    r = 7'd90;
            3'd1:    r = 7'd90;
            3'd2:    r = 7'd82;
            3'd3:    r = 7'd77;
            3'd4:    r = 7'd38;
            default: r = 7'd77;
        endcase
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [40:0] v);
        return v[40:31] != {10{v[31]}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (!ovf32(v)) r = v[31:0];
        else if (v[40]) r = 32'sh8000_0000;
        else r = 32'sh7fff_ffff;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/polyline_ribbon_extruder_core.sv =====
// polyline_ribbon_extruder_core: top level joining loader, job queue and emitter
// depends on pre_pkg, pre_front, pre_jobq, pre_back
//
// Usage: write the scene origin and elevation window on the cfg channel while idle
// (index 0 origin_x, 1 origin_y, 2 origin_z, 3 z_valid_low, 4 z_valid_high; cfg_ready
// is always high). Stream one road centreline on s_*, one point per beat, tlast on
// the final point. Points load at one per cycle. After the last point, s_tready drops
// until the whole road has been emitted on m_*, one beat per stored point, or a single
// status beat when the road is too short or has no valid elevation.
// Each ribbon beat is computed after the previous handshake by one-bit-per-step tangent
// normalization, an iterative square root and an 11-step divider for the offset; all
// three are skipped when the tangent is zero. The first beat takes the same path once
// the last point is accepted; a status beat skips that path entirely.
// A stalled m_tready holds the output register and the emitter; the loader stays
// closed until the road is done. Reset (aresetn low, synchronous) restores the
// register defaults and empties the loader, queue and emitter; the point store is
// not cleared.
`timescale 1ns / 1ps
`default_nettype none
module polyline_ribbon_extruder_core #(
    parameter int MAX_POINTS = pre_pkg::MAX_POINTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pre_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // point_x [39:0], point_y [79:40], point_z [111:80]
    input  wire logic [111:0]                   s_tdata,
    // road_class [2:0]
    input  wire logic [2:0]                     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // left_x [31:0], left_y [63:32], right_x [95:64], right_y [127:96],
    // vertex_z [159:128], point_index [165:160], zero fill [167:166]
    output logic [167:0]                        m_tdata,
    // road_class_out [2:0], status [4:3]
    output logic [4:0]                          m_tuser,
    output logic                                m_tlast
);
    import pre_pkg::*;

    mem_wr_t mem_wr;
    job_t    job_in, job_out;
    logic    job_push, job_pop, job_valid, busy;
    logic signed [Z_W-1:0] origin_z;

    pre_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .hold(busy || job_valid),
        .mem_wr(mem_wr), .job_push(job_push), .job(job_in), .origin_z(origin_z)
    );

    pre_jobq u_jobq (
        .aclk(aclk), .aresetn(aresetn),
        .push(job_push), .din(job_in),
        .pop(job_pop), .valid(job_valid), .dout(job_out)
    );

    pre_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .mem_wr(mem_wr),
        .job_valid(job_valid), .job(job_out), .job_pop(job_pop),
        .origin_z(origin_z), .busy(busy),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/pre_front.sv =====
// pre_front: configuration registers and point loader, classifies each road into a job
// depends on pre_pkg; writes the point store in pre_back and pushes jobs to pre_jobq
`timescale 1ns / 1ps
`default_nettype none
module pre_front #(
    parameter int MAX_POINTS = pre_pkg::MAX_POINTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pre_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [111:0]                    s_tdata,
    input  wire logic [pre_pkg::CLS_W-1:0]       s_tuser,
    input  wire logic                            s_tlast,
    input  wire logic                            hold,
    output pre_pkg::mem_wr_t                     mem_wr,
    output logic                                 job_push,
    output pre_pkg::job_t                        job,
    output logic signed [pre_pkg::Z_W-1:0]       origin_z
);
    import pre_pkg::*;

    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic signed [Z_W-1:0]     oz_reg, zlo_reg, zhi_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [IDX_W-1:0]          fv_reg;
    logic                      found_reg, ovf_reg;

    logic signed [COORD_W-1:0] px, py;
    logic signed [Z_W-1:0]     pz;
    logic signed [40:0]        rx, ry;
    logic                      acc, room, hit, ok;
    logic [CNT_W-1:0]          n_now;
    logic                      found_now, ovf_now;
    logic [IDX_W-1:0]          fv_now;

    assign cfg_ready = 1'b1;
    assign s_tready  = !hold;
    assign acc       = s_tvalid && s_tready;
    assign origin_z  = oz_reg;

    assign px   = $signed(s_tdata[39:0]);
    assign py   = $signed(s_tdata[79:40]);
    assign pz   = $signed(s_tdata[111:80]);
    assign rx   = 41'(px) - 41'(ox_reg);
    assign ry   = 41'(py) - 41'(oy_reg);
    assign hit  = ovf32(rx) || ovf32(ry);
    assign ok   = (pz > zlo_reg) && (pz < zhi_reg);
    assign room = cnt_reg < CNT_W'(MAX_POINTS);

    assign n_now     = room ? cnt_reg + 1'b1 : cnt_reg;
    assign found_now = found_reg || (room && ok);
    assign fv_now    = found_reg ? fv_reg : cnt_reg[IDX_W-1:0];
    assign ovf_now   = ovf_reg || !room || hit;

    always_comb begin
        mem_wr.we     = acc && room;
        mem_wr.addr   = cnt_reg[IDX_W-1:0];
        mem_wr.data.x = sat32(rx);
        mem_wr.data.y = sat32(ry);
        mem_wr.data.z = pz;
        mem_wr.data.ok = ok;
        job_push        = acc && s_tlast;
        job.n           = n_now;
        job.fv          = fv_now;
        job.cls         = s_tuser;
        job.status_only = (n_now < CNT_W'(2)) || !found_now;
        if (n_now < CNT_W'(2)) job.status = ST_SHORT;
        else if (!found_now) job.status = ST_NO_Z;
        else if (ovf_now) job.status = ST_OVF;
        else job.status = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg  <= '0;
            oy_reg  <= '0;
            oz_reg  <= '0;
            zlo_reg <= -32'sd128000;
            zhi_reg <= 32'sd2304000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ORIGIN_X: ox_reg  <= $signed(cfg_data);
                CFG_ORIGIN_Y: oy_reg  <= $signed(cfg_data);
                CFG_ORIGIN_Z: oz_reg  <= $signed(cfg_data[31:0]);
                CFG_Z_LOW:    zlo_reg <= $signed(cfg_data[31:0]);
                CFG_Z_HIGH:   zhi_reg <= $signed(cfg_data[31:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            fv_reg    <= '0;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (acc) begin
            if (s_tlast) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end else begin
                cnt_reg   <= n_now;
                found_reg <= found_now;
                fv_reg    <= fv_now;
                ovf_reg   <= ovf_now;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pre_jobq.sv =====
// pre_jobq: two-entry job queue between loader and emitter
// depends on pre_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none
module pre_jobq (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire pre_pkg::job_t din,
    input  wire logic    pop,
    output logic         valid,
    output pre_pkg::job_t dout
);
    import pre_pkg::*;

    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign valid   = cnt_reg != 2'd0;
    assign dout    = q_reg[rp_reg];
    assign do_push = push && (cnt_reg != 2'd2);
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) q_reg[wp_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_push) wp_reg <= !wp_reg;
            if (do_pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pre_back.sv =====
// pre_back: point store and ribbon emitter with iterative normalize, square root and divide
// depends on pre_pkg; takes jobs from pre_jobq and store writes from pre_front
`timescale 1ns / 1ps
`default_nettype none
module pre_back #(
    parameter int MAX_POINTS = pre_pkg::MAX_POINTS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pre_pkg::mem_wr_t            mem_wr,
    input  wire logic                        job_valid,
    input  wire pre_pkg::job_t               job,
    output logic                             job_pop,
    input  wire logic signed [pre_pkg::Z_W-1:0] origin_z,
    output logic                             busy,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [167:0]                     m_tdata,
    output logic [4:0]                       m_tuser,
    output logic                             m_tlast
);
    import pre_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    pt_word_t mem [MAX_POINTS];

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [ADDR_W-1:0] addr_reg;
    pt_word_t    rd_reg, prev_reg, cur_reg, nxt_reg;
    logic signed [Z_W-1:0] carry_reg;
    logic [IDX_W-1:0] i_reg;
    logic [32:0] a_reg, b_reg;
    logic        tx_neg_reg, ty_pos_reg;
    logic [61:0] asq_reg, bsq_reg;
    logic [62:0] v_reg, r_reg, bit_reg;
    logic [31:0] len_reg;
    logic [43:0] numx_reg, numy_reg;
    logic [3:0]  k_reg;
    logic [HW_W-1:0] qx_reg, qy_reg;
    logic signed [31:0] olx_reg, oly_reg, orx_reg, ory_reg, ovz_reg;
    logic [IDX_W-1:0] oidx_reg;
    logic        olast_reg;

    logic signed [32:0] dx, dy;
    logic [32:0] mx;
    logic [62:0] rb;
    logic [43:0] dvx;
    logic signed [11:0] ox, oy;
    logic [CNT_W-1:0] i_ext, nm1, adv;
    logic [HW_W-1:0] hw;
    logic is_last;

    assign hw      = half_width(job_reg.cls);
    assign dx      = 33'(nxt_reg.x) - 33'(prev_reg.x);
    assign dy      = 33'(nxt_reg.y) - 33'(prev_reg.y);
    assign mx      = (a_reg > b_reg) ? a_reg : b_reg;
    assign rb      = r_reg + bit_reg;
    assign dvx     = 44'(len_reg) << k_reg;
    assign ox      = ty_pos_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign oy      = tx_neg_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
    assign i_ext   = CNT_W'(i_reg);
    assign nm1     = job_reg.n - 1'b1;
    assign adv     = (i_ext + CNT_W'(2) < nm1) ? i_ext + CNT_W'(2) : nm1;
    assign is_last = (i_ext == nm1);

    assign busy     = state_reg != B_IDLE;
    assign m_tvalid = state_reg == B_OUT;
    assign m_tdata  = {2'b00, oidx_reg, ovz_reg, ory_reg, orx_reg, oly_reg, olx_reg};
    assign m_tuser  = {job_reg.status, job_reg.cls};
    assign m_tlast  = olast_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr.we) mem[mem_wr.addr[ADDR_W-1:0]] <= mem_wr.data;
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= B_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        job_pop    = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    state_next = job.status_only ? B_OUT : B_FV;
                end
            end
            B_FV:   state_next = B_P0;
            B_P0:   state_next = B_P1;
            B_P1:   state_next = B_NCAP;
            B_NRD:  state_next = B_NCAP;
            B_NCAP: state_next = B_TAN;
            B_TAN:  state_next = (dx == '0 && dy == '0) ? B_FIN : B_NORM;
            B_NORM: if (mx[32:31] == 2'b00 && mx[30]) state_next = B_SQ;
            B_SQ:   state_next = B_SUM;
            B_SUM:  state_next = B_SQRT;
            B_SQRT: if (bit_reg == '0) state_next = B_MUL;
            B_MUL:  state_next = B_DIV;
            B_DIV:  if (k_reg == 4'd0) state_next = B_FIN;
            B_FIN:  state_next = B_OUT;
            B_OUT: begin
                if (m_tready) state_next = olast_reg ? B_IDLE : B_NRD;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                job_reg   <= job;
                addr_reg  <= job.fv[ADDR_W-1:0];
                i_reg     <= '0;
                olx_reg   <= '0;
                oly_reg   <= '0;
                orx_reg   <= '0;
                ory_reg   <= '0;
                ovz_reg   <= '0;
                oidx_reg  <= '0;
                olast_reg <= 1'b1;
            end
            B_FV: addr_reg <= '0;
            B_P0: begin
                carry_reg <= rd_reg.z;
                addr_reg  <= ADDR_W'(1);
            end
            B_P1: begin
                prev_reg <= rd_reg;
                cur_reg  <= rd_reg;
            end
            B_NCAP: begin
                nxt_reg <= rd_reg;
                if (cur_reg.ok) carry_reg <= cur_reg.z;
            end
            B_TAN: begin
                a_reg      <= dx[32] ? 33'(-dx) : 33'(dx);
                b_reg      <= dy[32] ? 33'(-dy) : 33'(dy);
                tx_neg_reg <= dx[32];
                ty_pos_reg <= !dy[32] && (dy != '0);
                qx_reg     <= hw;
                qy_reg     <= '0;
                if (dx == '0 && dy == '0) begin
                    tx_neg_reg <= 1'b0;
                    ty_pos_reg <= 1'b0;
                end
            end
            B_NORM: begin
                if (mx[32:31] != 2'b00) begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end else if (!mx[30]) begin
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg << 1;
                end
            end
            B_SQ: begin
                asq_reg <= a_reg[30:0] * a_reg[30:0];
                bsq_reg <= b_reg[30:0] * b_reg[30:0];
            end
            B_SUM: begin
                v_reg   <= 63'(asq_reg) + 63'(bsq_reg);
                r_reg   <= '0;
                bit_reg <= 63'(1) << 62;
            end
            B_SQRT: begin
                if (bit_reg == '0) begin
                    len_reg <= r_reg[31:0];
                end else begin
                    if (v_reg >= rb) begin
                        v_reg <= v_reg - rb;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            B_MUL: begin
                numx_reg <= 44'(b_reg[30:0]) * 44'(hw) + 44'(len_reg >> 1);
                numy_reg <= 44'(a_reg[30:0]) * 44'(hw) + 44'(len_reg >> 1);
                qx_reg   <= '0;
                qy_reg   <= '0;
                k_reg    <= 4'd10;
            end
            B_DIV: begin
                if (numx_reg >= dvx) begin
                    numx_reg       <= numx_reg - dvx;
                    qx_reg[k_reg]  <= 1'b1;
                end
                if (numy_reg >= dvx) begin
                    numy_reg       <= numy_reg - dvx;
                    qy_reg[k_reg]  <= 1'b1;
                end
                k_reg <= k_reg - 1'b1;
            end
            B_FIN: begin
                olx_reg   <= sat32(41'(cur_reg.x) + 41'(ox));
                oly_reg   <= sat32(41'(cur_reg.y) + 41'(oy));
                orx_reg   <= sat32(41'(cur_reg.x) - 41'(ox));
                ory_reg   <= sat32(41'(cur_reg.y) - 41'(oy));
                ovz_reg   <= sat32(41'(carry_reg) - 41'(origin_z)
                                   + 41'($signed({1'b0, lift(job_reg.cls)})));
                oidx_reg  <= i_reg;
                olast_reg <= is_last;
            end
            B_OUT: begin
                if (m_tready) begin
                    prev_reg <= cur_reg;
                    cur_reg  <= nxt_reg;
                    i_reg    <= i_reg + 1'b1;
                    addr_reg <= adv[ADDR_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SQ) |-> (a_reg[32:31] == 2'b00 && b_reg[32:31] == 2'b00
                                 && (a_reg[30] || b_reg[30])))
        else $error("tangent not normalized");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FIN) |-> (qx_reg <= hw && qy_reg <= hw))
        else $error("offset exceeds half width");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && !job_reg.status_only) |-> (CNT_W'(oidx_reg) == nm1))
        else $error("last beat not at final point");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_MUL) |-> (len_reg[31:30] != 2'b00))
        else $error("root below normalized magnitude");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for polyline_ribbon_extruder_core with a built-in ribbon predictor
// depends on pre_pkg and the rtl of the core; stream driver and result monitor are clocked blocks,
// the driver fed by a queue of pending beats, mixed with register writes and idle points
`timescale 1ns / 1ps
module tb_top;
    import pre_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {PK_POINT, PK_REG, PK_SETTLE} pend_kind_t;

    typedef struct {
        pend_kind_t     kind;
        logic [39:0]    px;
        logic [39:0]    py;
        logic [31:0]    pz;
        logic [2:0]     cls;
        logic           last;
        logic [2:0]     reg_idx;
        logic [39:0]    reg_val;
        int             phase;
    } pend_t;

    typedef struct packed {
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] vz;
        logic [5:0]  idx;
        logic [2:0]  cls;
        logic [1:0]  st;
        logic        last;
    } vertex_pair_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [39:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;

    polyline_ribbon_extruder_core uut (.*);

    pend_t        pend_q[$];
    vertex_pair_t ribbon_q[$];
    int           fails = 0;
    int           cycles = 0;
    int           quiet = 0;
    int           phase = 0;
    logic         hs_s = 1'b0;
    logic         hs_c = 1'b0;

    // predictor state
    longint  org_x = 0, org_y = 0, org_z = 0, zlo = -128000, zhi = 2304000;
    int      rel_x[64], rel_y[64], raw_z[64];
    bit      z_ok[64];
    int      pt_cnt = 0, first_ok = 127, road_cls = 0;
    bit      road_ovf = 0;

    // generator view of the origin and elevation window
    longint  gen_ox = 0, gen_oy = 0, gen_zlo = -128000, gen_zhi = 2304000;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int clamp32(longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            hit = 1;
            return 32'h80000000;
        end
        return int'(v);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic extrude_road();
        int unsigned  n = pt_cnt;
        bit           hit;
        vertex_pair_t v;
        longint       hw, lft, carry, tx, ty, ox, oy, cx, cy;
        longint unsigned a, b, m, len, qx, qy;
        hw  = half_width(road_cls[2:0]);
        lft = lift(road_cls[2:0]);
        if (n < 2 || first_ok >= n) begin
            v = '0;
            v.cls = road_cls[2:0];
            v.st = (n < 2) ? ST_SHORT : ST_NO_Z;
            v.last = 1'b1;
            ribbon_q = {ribbon_q, v};
        end else begin
            carry = raw_z[first_ok];
            for (int i = 0; i < n; i++) begin
                cx = rel_x[i];
                cy = rel_y[i];
                tx = longint'(rel_x[(i + 1 < n) ? i + 1 : i]) - rel_x[(i > 0) ? i - 1 : i];
                ty = longint'(rel_y[(i + 1 < n) ? i + 1 : i]) - rel_y[(i > 0) ? i - 1 : i];
                if (z_ok[i]) carry = raw_z[i];
                if (tx == 0 && ty == 0) begin
                    ox = hw;
                    oy = 0;
                end else begin
                    a = (tx < 0) ? -tx : tx;
                    b = (ty < 0) ? -ty : ty;
                    m = (a > b) ? a : b;
                    while (m >= (64'd1 << 31)) begin
                        a >>= 1; b >>= 1; m >>= 1;
                    end
                    while (m < (64'd1 << 30)) begin
                        a <<= 1; b <<= 1; m <<= 1;
                    end
                    len = root_floor(a * a + b * b);
                    qx = (b * hw + len / 2) / len;
                    qy = (a * hw + len / 2) / len;
                    ox = (ty > 0) ? -longint'(qx) : longint'(qx);
                    oy = (tx < 0) ? -longint'(qy) : longint'(qy);
                end
                v.lx = clamp32(cx + ox, hit);
                v.ly = clamp32(cy + oy, hit);
                v.rx = clamp32(cx - ox, hit);
                v.ry = clamp32(cy - oy, hit);
                v.vz = clamp32(carry - org_z + lft, hit);
                v.idx = i[5:0];
                v.cls = road_cls[2:0];
                v.st = road_ovf ? ST_OVF : ST_OK;
                v.last = (i + 1 == n);
                ribbon_q = {ribbon_q, v};
            end
        end
        pt_cnt = 0;
        first_ok = 127;
        road_ovf = 0;
    endtask

    task automatic load_point(pend_t p);
        longint px, py, pz;
        bit     hit = 0, ok;
        px = $signed(p.px);
        py = $signed(p.py);
        pz = $signed(p.pz);
        road_cls = p.cls;
        if (pt_cnt < 64) begin
            ok = (pz > zlo) && (pz < zhi);
            rel_x[pt_cnt] = clamp32(px - org_x, hit);
            rel_y[pt_cnt] = clamp32(py - org_y, hit);
            raw_z[pt_cnt] = int'(pz);
            z_ok[pt_cnt] = ok;
            if (hit) road_ovf = 1;
            if (ok && first_ok == 127) first_ok = pt_cnt;
            pt_cnt++;
        end else begin
            road_ovf = 1;
        end
        if (p.last) extrude_road();
    endtask

    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        case (idx)
            CFG_ORIGIN_X: org_x = $signed(val);
            CFG_ORIGIN_Y: org_y = $signed(val);
            CFG_ORIGIN_Z: org_z = $signed(val[31:0]);
            CFG_Z_LOW:    zlo = $signed(val[31:0]);
            CFG_Z_HIGH:   zhi = $signed(val[31:0]);
            default: ;
        endcase
    endtask

    // stimulus builders
    task automatic add_point(longint x, longint y, longint z, int cls, bit last);
        pend_t p;
        p.kind = PK_POINT;
        p.px = x[39:0];
        p.py = y[39:0];
        p.pz = z[31:0];
        p.cls = cls[2:0];
        p.last = last;
        pend_q = {pend_q, p};
    endtask

    task automatic add_reg(logic [2:0] idx, longint val);
        pend_t p;
        p.kind = PK_REG;
        p.reg_idx = idx;
        p.reg_val = val[39:0];
        pend_q = {pend_q, p};
        case (idx)
            CFG_ORIGIN_X: gen_ox = val;
            CFG_ORIGIN_Y: gen_oy = val;
            CFG_Z_LOW:    gen_zlo = val;
            CFG_Z_HIGH:   gen_zhi = val;
            default: ;
        endcase
    endtask

    task automatic add_settle(int ph);
        pend_t p;
        p.kind = PK_SETTLE;
        p.phase = ph;
        pend_q = {pend_q, p};
    endtask

    function automatic longint rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic longint good_z();
        longint span = gen_zhi - gen_zlo;
        if (span <= 2) return gen_zlo + 1;
        if (span > 64'd4000000000) span = 64'd4000000000;
        return gen_zlo + 1 + (rnd64() & 64'h7fffffffffff) % (span - 1);
    endfunction

    function automatic longint bad_z();
        if ($urandom_range(1) && gen_zlo > -64'sd2147483648)
            return gen_zlo - $urandom_range(3);
        if (gen_zhi < 64'sd2147483647) return gen_zhi + $urandom_range(3);
        return gen_zlo;
    endfunction

    // one road of random content, mostly well formed; returns its point count
    task automatic add_road(int len, output int used);
        longint x, y, sx, sy;
        int     cls, zmode;
        cls = $urandom_range(5);
        zmode = $urandom_range(9);
        x = gen_ox + $signed($urandom()) / 4;
        y = gen_oy + $signed($urandom()) / 4;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: begin x = rnd64(); y = rnd64(); end
                1: ;
                2: begin x += $signed($urandom()); y -= $signed($urandom()); end
                default: begin
                    sx = $signed($urandom_range(8191)) - 4096;
                    sy = $signed($urandom_range(8191)) - 4096;
                    x += sx;
                    y += sy;
                end
            endcase
            add_point(x, y,
                      (zmode == 0) ? bad_z() :
                      ($urandom_range(4) == 0 ? ((zmode == 1) ? rnd64() : bad_z()) : good_z()),
                      ($urandom_range(7) == 0) ? $urandom_range(5) : cls, i == len - 1);
        end
        used = len;
    endtask

    task automatic add_random(int count);
        int used, len;
        while (count > 0) begin
            case ($urandom_range(15))
                0: len = 1;
                1: len = $urandom_range(30, 12);
                default: len = $urandom_range(8, 2);
            endcase
            add_road(len, used);
            count -= used;
        end
    endtask

    // driver: all inputs change on the falling edge
    always @(negedge aclk) begin
        quiet <= (ribbon_q.size() == 0) ? quiet + 1 : 0;
        if (aresetn) begin
            m_tready <= (phase == 0) ? ($urandom_range(99) >= 54) :
                        (phase == 1) ? ($urandom_range(99) >= 37) : 1'b1;
            if (cfg_valid && !hs_c) begin
            end else if (s_tvalid && !hs_s) begin
                cfg_valid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                s_tvalid <= 1'b0;
                cfg_valid <= 1'b0;
            end else begin
                case (pend_q[0].kind)
                    PK_SETTLE: begin
                        s_tvalid <= 1'b0;
                        cfg_valid <= 1'b0;
                        if (ribbon_q.size() == 0 && quiet >= 40) begin
                            phase <= pend_q[0].phase;
                            void'(pend_q.pop_front());
                        end
                    end
                    PK_REG: begin
                        s_tvalid <= 1'b0;
                        cfg_valid <= 1'b1;
                        cfg_index <= pend_q[0].reg_idx;
                        cfg_data <= pend_q[0].reg_val;
                        void'(pend_q.pop_front());
                    end
                    default: begin
                        cfg_valid <= 1'b0;
                        if ((phase == 0 && $urandom_range(99) < 37) ||
                            (phase == 1 && $urandom_range(99) < 54)) begin
                            s_tvalid <= 1'b0;
                        end else begin
                            s_tvalid <= 1'b1;
                            s_tdata <= {pend_q[0].pz, pend_q[0].py, pend_q[0].px};
                            s_tuser <= pend_q[0].cls;
                            s_tlast <= pend_q[0].last;
                            void'(pend_q.pop_front());
                        end
                    end
                endcase
            end
        end
    end

    // monitor: beats sampled on the rising edge
    always @(posedge aclk) begin
        pend_t        p;
        vertex_pair_t got, want;
        cycles <= cycles + 1;
        hs_s <= s_tvalid && s_tready;
        hs_c <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                p.px = s_tdata[39:0];
                p.py = s_tdata[79:40];
                p.pz = s_tdata[111:80];
                p.cls = s_tuser;
                p.last = s_tlast;
                load_point(p);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                       m_tdata[159:128], m_tdata[165:160], m_tuser[2:0], m_tuser[4:3],
                       m_tlast};
                if (ribbon_q.size() == 0) begin
                    fails <= fails + 1;
                    $display("%0t unexpected beat %h", $time, got);
                end else begin
                    want = ribbon_q.pop_front();
                    if (got !== want) begin
                        fails <= fails + 1;
                        $display("%0t mismatch expected %h actual %h", $time, want, got);
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int used;
        // phase 0: register defaults, directed roads, then random roads
        add_reg(CFG_ORIGIN_X, 0);
        add_reg(CFG_ORIGIN_Y, 0);
        add_reg(CFG_ORIGIN_Z, 0);
        add_reg(CFG_Z_LOW, -128000);
        add_reg(CFG_Z_HIGH, 2304000);
        add_point(100, 200, 5000, 0, 1);                         // single point
        add_point(0, 0, -128000, 1, 0);                          // no valid elevation
        add_point(256, 0, 2304000, 1, 1);
        add_point(0, 0, 9999999, 2, 0);                          // leading fill, gaps
        add_point(1000, 0, 3000, 2, 0);
        add_point(1000, 0, -200000, 2, 0);                       // zero tangent neighbor
        add_point(1000, 0, 2303999, 2, 0);
        add_point(2000, 500, -127999, 2, 1);
        add_point(5, 5, 100, 3, 0);                              // all points equal
        add_point(5, 5, 100, 3, 1);
        add_point(64'sh7fffffffff, 64'sh7fffffffff, 32'h7fffffff, 4, 0); // saturation
        add_point(-64'sh8000000000, -64'sh8000000000, 32'h80000000, 4, 0);
        add_point(0, 0, 0, 4, 1);
        add_point(2147483000, -2147483000, 77, 5, 0);            // vertex clamp
        add_point(2147483000, -2147483000, 77, 5, 0);
        add_point(2147483647, -2147483648, 77, 5, 1);
        add_point(-300, 700, 1, 7, 0);
        add_point(300, -700, 1, 6, 1);
        add_random(40);
        add_settle(0);                                           // sender waits for drain
        add_random(80);
        add_settle(1);
        add_reg(CFG_ORIGIN_X, 64'sh7fffffffff);
        add_reg(CFG_ORIGIN_Y, -64'sh8000000000);
        add_reg(CFG_ORIGIN_Z, 32'sh7fffffff);
        add_reg(CFG_Z_LOW, -64'sd2147483648);
        add_reg(CFG_Z_HIGH, 64'sd2147483647);
        add_random(110);
        add_settle(2);
        add_reg(CFG_ORIGIN_X, -123456789);
        add_reg(CFG_ORIGIN_Y, 987654321);
        add_reg(CFG_ORIGIN_Z, -64'sd2147483648);
        add_reg(CFG_Z_LOW, 0);
        add_reg(CFG_Z_HIGH, 1000000);
        add_road(70, used);                                       // too many points
        add_random(60);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (pend_q.size() == 0);
        @(negedge aclk);
        while (s_tvalid || ribbon_q.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/pre_pkg.sv
rtl/pre_front.sv
rtl/pre_jobq.sv
rtl/pre_back.sv
rtl/polyline_ribbon_extruder_core.sv
verif/tb_top.sv
